// ----- src/antialiased_line_raster_top_macros.svh -----
// Assertion macros shared by the line raster RTL.
`ifndef ANTIALIASED_LINE_RASTER_TOP_MACROS_SVH
`define ANTIALIASED_LINE_RASTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ALR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ALR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/alr_pkg.sv -----
// Shared types and constants of the anti-aliased line raster.
`timescale 1ns / 1ps

package alr_pkg;

    localparam int COLOR_W = 24;
    localparam int ALPHA_W = 8;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_DIV   = 2'b10
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- src/alr_ifs.sv -----
// Request and pixel channel interfaces of the line raster.
`timescale 1ns / 1ps

interface alr_req_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface alr_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic [COORD_BITS-1:0]        near_x;
    logic [COORD_BITS-1:0]        near_y;
    logic [alr_pkg::ALPHA_W-1:0]  near_alpha;
    logic [COORD_BITS:0]          far_x;
    logic [COORD_BITS:0]          far_y;
    logic [alr_pkg::ALPHA_W-1:0]  far_alpha;
    logic                         far_valid;
    logic [alr_pkg::COLOR_W-1:0]  out_color;
    logic                         last;

    modport source (
        output valid, near_x, near_y, near_alpha, far_x, far_y, far_alpha,
               far_valid, out_color, last,
        input  ready
    );
    modport sink (
        input  valid, near_x, near_y, near_alpha, far_x, far_y, far_alpha,
               far_valid, out_color, last,
        output ready
    );
endinterface

// ----- src/alr_div.sv -----
// Radix-2 restoring divider for the line gradient, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "antialiased_line_raster_top_macros.svh"

module alr_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COORD_BITS-1:0]  num,
    input  logic [COORD_BITS-1:0]  den,
    output alr_pkg::div_status_t   status,
    output logic [FRAC_BITS:0]     quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] den_reg, den_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  ge;
    logic [COORD_BITS:0]   diff;

    // num <= den, so the quotient of num * 2^FRAC_BITS / den fits FRAC_BITS+1 bits
    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            cnt_next  = CNT_W'(FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[FRAC_BITS-1:0], ge};
            rem_next = {diff[COORD_BITS-1:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

    `ALR_ASSERT_IMP(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `ALR_ASSERT_NXT(a_done_ends, busy_reg && cnt_reg == '0 && !start, done_reg && !busy_reg,
        "divider did not finish after its last bit")

endmodule

// ----- src/antialiased_line_raster_top.sv -----
// Top level of the anti-aliased line raster: request decode, step datapath, result register.
//
//   channel   dir   beat
//   req       in    req_type, start_x, start_y, end_x, end_y
//   pix       out   near/far pixel pair, alphas, far_valid, out_color, last
//   cfg_*     in    pixel_color write, no handshake
//
// Step requests and axis-aligned starts never enter the divide state.
// A sloped start emits its first endpoint at once, then holds off requests in ST_DIV
// while the divider forms the gradient one bit a cycle.
// A result waits in the output register; a new request is taken as it drains.
// rst_n clears control state and pixel_color; no clearing pass.
`timescale 1ns / 1ps
`include "antialiased_line_raster_top_macros.svh"

module antialiased_line_raster_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [alr_pkg::COLOR_W-1:0] cfg_wdata,
    alr_req_if.sink                     req,
    alr_pix_if.source                   pix
);

    localparam int C     = COORD_BITS;
    localparam int ACC_W = COORD_BITS + FRAC_BITS;
    localparam int AW    = alr_pkg::ALPHA_W;

    alr_pkg::state_t state_reg, state_next;

    logic [alr_pkg::COLOR_W-1:0] pixel_color_reg;

    logic             active_reg, active_next;
    logic             minor_is_x_reg, minor_is_x_next;
    logic             aligned_reg, aligned_next;
    logic [C-1:0]     major_pos_reg, major_pos_next;
    logic [C-1:0]     major_end_reg, major_end_next;
    logic [C-1:0]     minor_end_reg, minor_end_next;
    logic [ACC_W-1:0] accum_reg, accum_next;
    logic [FRAC_BITS:0] gradient_reg, gradient_next;
    logic             gneg_reg, gneg_next;

    // result register
    logic             out_valid_reg;
    logic [C-1:0]     near_x_reg, near_y_reg;
    logic [AW-1:0]    near_alpha_reg, far_alpha_reg;
    logic [C:0]       far_x_reg, far_y_reg;
    logic             far_valid_reg, last_reg;
    logic [alr_pkg::COLOR_W-1:0] color_reg;

    // result being formed
    logic             emit;
    logic [C-1:0]     r_near_x, r_near_y;
    logic [AW-1:0]    r_near_alpha, r_far_alpha;
    logic [C:0]       r_far_x, r_far_y;
    logic             r_far_valid, r_last;

    logic accept;
    logic div_start;
    alr_pkg::div_status_t div_stat;
    logic [FRAC_BITS:0]   div_quo;

    // start decode
    logic [C-1:0] dx, dy, ax0, ay0, ax1, ay1;
    logic [C-1:0] s_major0, s_major_end, s_minor0, s_minor_end, d_major, d_minor;
    logic         s_mix, s_aligned, s_swap, s_last;

    // step datapath
    logic [C-1:0]         ip;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS+AW-1:0] vprod;
    logic [AW-1:0]        a_floor, a_ceil;
    logic                 single_step;
    logic [C-1:0]         s_major_sel;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == alr_pkg::ST_READY) && (!out_valid_reg || pix.ready);

    always_comb
    begin
        dx = (req.end_x > req.start_x) ? (req.end_x - req.start_x) : (req.start_x - req.end_x);
        dy = (req.end_y > req.start_y) ? (req.end_y - req.start_y) : (req.start_y - req.end_y);
        // minor axis is x on a tie and for vertical or single-point lines
        s_mix     = dy >= dx;
        s_aligned = (dx == '0) || (dy == '0);
        s_swap    = s_mix ? (req.end_y < req.start_y) : (req.end_x < req.start_x);
        ax0 = s_swap ? req.end_x : req.start_x;
        ay0 = s_swap ? req.end_y : req.start_y;
        ax1 = s_swap ? req.start_x : req.end_x;
        ay1 = s_swap ? req.start_y : req.end_y;
        s_major0    = s_mix ? ay0 : ax0;
        s_major_end = s_mix ? ay1 : ax1;
        s_minor0    = s_mix ? ax0 : ay0;
        s_minor_end = s_mix ? ax1 : ay1;
        d_major     = s_mix ? dy : dx;
        d_minor     = s_mix ? dx : dy;
        s_last      = s_aligned && (s_major0 == s_major_end);
    end

    always_comb
    begin
        ip      = accum_reg[ACC_W-1:FRAC_BITS];
        frac    = accum_reg[FRAC_BITS-1:0];
        // frac * 255
        vprod   = {frac, {AW{1'b0}}} - {{AW{1'b0}}, frac};
        a_floor = vprod[FRAC_BITS+AW-1:FRAC_BITS];
        a_ceil  = a_floor + AW'(|vprod[FRAC_BITS-1:0]);
        single_step = aligned_reg || (major_pos_reg >= major_end_reg);
        s_major_sel = aligned_reg ? major_pos_reg : major_end_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        minor_is_x_next = minor_is_x_reg;
        aligned_next    = aligned_reg;
        major_pos_next  = major_pos_reg;
        major_end_next  = major_end_reg;
        minor_end_next  = minor_end_reg;
        accum_next      = accum_reg;
        gradient_next   = gradient_reg;
        gneg_next       = gneg_reg;
        div_start       = 1'b0;
        emit            = 1'b0;
        r_near_x        = '0;
        r_near_y        = '0;
        r_near_alpha    = alr_pkg::ALPHA_MAX;
        r_far_x         = '0;
        r_far_y         = '0;
        r_far_alpha     = '0;
        r_far_valid     = 1'b0;
        r_last          = 1'b0;

        case (state_reg)
            alr_pkg::ST_READY:
            begin
                if (accept && req.req_type == alr_pkg::REQ_START)
                begin
                    emit            = 1'b1;
                    r_near_x        = s_mix ? s_minor0 : s_major0;
                    r_near_y        = s_mix ? s_major0 : s_minor0;
                    r_last          = s_last;
                    active_next     = !s_last;
                    minor_is_x_next = s_mix;
                    aligned_next    = s_aligned;
                    major_pos_next  = s_major0 + 1'b1;
                    major_end_next  = s_major_end;
                    minor_end_next  = s_minor_end;
                    gneg_next       = s_minor_end < s_minor0;
                    accum_next      = {s_minor0, {FRAC_BITS{1'b0}}};
                    gradient_next   = '0;
                    if (!s_aligned)
                    begin
                        div_start  = 1'b1;
                        state_next = alr_pkg::ST_DIV;
                    end
                end
                else if (accept && active_reg)
                begin
                    emit = 1'b1;
                    if (single_step)
                    begin
                        r_near_x = minor_is_x_reg ? minor_end_reg : s_major_sel;
                        r_near_y = minor_is_x_reg ? s_major_sel : minor_end_reg;
                        r_last   = major_pos_reg >= major_end_reg;
                        if (major_pos_reg >= major_end_reg)
                            active_next = 1'b0;
                        else
                            major_pos_next = major_pos_reg + 1'b1;
                    end
                    else
                    begin
                        r_far_valid = 1'b1;
                        r_far_alpha = a_floor;
                        r_near_alpha = alr_pkg::ALPHA_MAX - (minor_is_x_reg ? a_floor : a_ceil);
                        if (minor_is_x_reg)
                        begin
                            r_near_x = ip;
                            r_near_y = major_pos_reg;
                            r_far_x  = {1'b0, ip} + 1'b1;
                            r_far_y  = {1'b0, major_pos_reg};
                        end
                        else
                        begin
                            r_near_x = major_pos_reg;
                            r_near_y = ip;
                            r_far_x  = {1'b0, major_pos_reg};
                            r_far_y  = {1'b0, ip} + 1'b1;
                        end
                        accum_next = gneg_reg ? (accum_reg - ACC_W'(gradient_reg))
                                              : (accum_reg + ACC_W'(gradient_reg));
                        major_pos_next = major_pos_reg + 1'b1;
                    end
                end
            end
            alr_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    gradient_next = div_quo;
                    // step to the first interior position
                    accum_next = gneg_reg ? (accum_reg - ACC_W'(div_quo))
                                          : (accum_reg + ACC_W'(div_quo));
                    state_next = alr_pkg::ST_READY;
                end
            end
            default:
            begin
                state_next = alr_pkg::ST_READY;
            end
        endcase
    end

    alr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (d_minor),
        .den      (d_major),
        .status   (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= alr_pkg::ST_READY;
            pixel_color_reg <= '0;
            active_reg      <= 1'b0;
            minor_is_x_reg  <= 1'b0;
            aligned_reg     <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_end_reg   <= '0;
            accum_reg       <= '0;
            gradient_reg    <= '0;
            gneg_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            minor_is_x_reg <= minor_is_x_next;
            aligned_reg    <= aligned_next;
            major_pos_reg  <= major_pos_next;
            major_end_reg  <= major_end_next;
            minor_end_reg  <= minor_end_next;
            accum_reg      <= accum_next;
            gradient_reg   <= gradient_next;
            gneg_reg       <= gneg_next;
            if (cfg_we)
                pixel_color_reg <= cfg_wdata;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            near_x_reg     <= r_near_x;
            near_y_reg     <= r_near_y;
            near_alpha_reg <= r_near_alpha;
            far_x_reg      <= r_far_x;
            far_y_reg      <= r_far_y;
            far_alpha_reg  <= r_far_alpha;
            far_valid_reg  <= r_far_valid;
            last_reg       <= r_last;
            color_reg      <= pixel_color_reg;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.near_x     = near_x_reg;
    assign pix.near_y     = near_y_reg;
    assign pix.near_alpha = near_alpha_reg;
    assign pix.far_x      = far_x_reg;
    assign pix.far_y      = far_y_reg;
    assign pix.far_alpha  = far_alpha_reg;
    assign pix.far_valid  = far_valid_reg;
    assign pix.out_color  = color_reg;
    assign pix.last       = last_reg;

    `ALR_ASSERT_IMP(a_done_in_div, div_stat.done, state_reg == alr_pkg::ST_DIV,
        "divider finished outside the divide state")
    `ALR_ASSERT_NXT(a_slope_divides, div_start, state_reg == alr_pkg::ST_DIV && div_stat.busy,
        "sloped start did not enter the divide")
    `ALR_ASSERT_IMP(a_pair_not_last, pix.valid && pix.far_valid, !pix.last,
        "interior pixel pair marked last")
    `ALR_ASSERT_IMP(a_alpha_sum, pix.valid && pix.far_valid,
        ({1'b0, pix.near_alpha} + {1'b0, pix.far_alpha} == 9'd255) ||
        ({1'b0, pix.near_alpha} + {1'b0, pix.far_alpha} == 9'd254),
        "pixel pair coverage does not add up")

endmodule
